@@ hw/rtl/key_tap_hold_tracker_top_macros.svh @@
// ----------------------------------------------------------------------------
// key_tap_hold_tracker_top_macros
// Assertion macros used by the checker file kth_checker.
// ----------------------------------------------------------------------------
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef KEY_TAP_HOLD_TRACKER_TOP_MACROS_SVH
`define KEY_TAP_HOLD_TRACKER_TOP_MACROS_SVH

// Same-cycle implication.
`define KTH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KTH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/kth_pkg.sv @@
// ----------------------------------------------------------------------------
// kth_pkg
// Types, codes and helpers of the key tap/hold tracker.
// ----------------------------------------------------------------------------
package kth_pkg;

    localparam int KEY_SLOTS_DEFAULT = 512;
    localparam int APB_AW            = 4;
    localparam int APB_DW            = 64;

    localparam logic [63:0] TAP_WINDOW_RESET = 64'd300000000;
    localparam logic [11:0] MOD_KEY_BASE     = 12'd340;
    localparam logic [7:0]  TAPS_MAX         = 8'd255;

    // commands
    localparam logic [2:0] CMD_PRESS     = 3'd0;
    localparam logic [2:0] CMD_RELEASE   = 3'd1;
    localparam logic [2:0] CMD_CHAR      = 3'd2;
    localparam logic [2:0] CMD_QUERY     = 3'd3;
    localparam logic [2:0] CMD_RESET_TAP = 3'd4;
    localparam logic [2:0] CMD_SET_LATCH = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_EVENT  = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_ACK    = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    // event actions
    localparam logic [1:0] ACT_RELEASE = 2'd0;
    localparam logic [1:0] ACT_PRESS   = 2'd1;
    localparam logic [1:0] ACT_REPEAT  = 2'd2;
    localparam logic [1:0] ACT_CHAR    = 2'd3;

    // tap phases
    localparam logic [2:0] PHASE_NONE    = 3'd0;
    localparam logic [2:0] PHASE_PENDING = 3'd1;
    localparam logic [2:0] PHASE_SINGLE  = 3'd2;
    localparam logic [2:0] PHASE_DOUBLE  = 3'd3;
    localparam logic [2:0] PHASE_MULTI   = 3'd4;

    // register index
    localparam logic REG_TAP_WINDOW = 1'b0;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [11:0] key_id;
        logic [31:0] window_id;
        logic [15:0] char_code;
        logic [63:0] now_nanos;
        logic [45:0] elapsed_micros;
        logic        latch_value;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] event_word;
        logic [31:0] event_window;
        logic [7:0]  tap_count;
        logic [2:0]  tap_phase;
        logic        key_held;
        logic        long_press_latched;
        logic [63:0] hold_nanos;
        logic [63:0] since_release_nanos;
    } result_t;

    // one table entry per key
    typedef struct packed {
        logic [63:0] press_stamp;
        logic [63:0] release_stamp;
        logic [63:0] tap_deadline;
        logic [63:0] hold_length;
        logic [7:0]  taps_so_far;
        logic [3:0]  mods_at_tap;
        logic        hold_latch;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // left/right modifier keys folded into shift, control, alt, super
    function automatic logic [3:0] mod_nibble(input logic [7:0] down);
        return down[3:0] | down[7:4];
    endfunction

    // one-hot modifier bit of a key code, zero for other keys
    function automatic logic [7:0] mod_mask(input logic [11:0] code);
        logic [11:0] off;
        off = code - MOD_KEY_BASE;
        if (code >= MOD_KEY_BASE && off < 12'd8)
            return 8'b1 << off[2:0];
        return 8'b0;
    endfunction

    function automatic logic [63:0] pack_word(input logic [45:0] micros,
                                              input logic [3:0]  mods,
                                              input logic [15:0] code,
                                              input logic [1:0]  action);
        return {micros, 18'b0} | {46'b0, mods, 14'b0} | {46'b0, code, 2'b0}
             | {62'b0, action};
    endfunction

endpackage

@@ hw/rtl/kth_ram.sv @@
// ----------------------------------------------------------------------------
// kth_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/kth_regs.sv @@
// ----------------------------------------------------------------------------
// kth_regs
// APB configuration register: tap window in nanoseconds.
// ----------------------------------------------------------------------------
module kth_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kth_pkg::APB_AW-1:0] paddr,
    input  logic [kth_pkg::APB_DW-1:0] pwdata,
    output logic [kth_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output logic [63:0]                tap_window
);
    import kth_pkg::*;

    logic [63:0] tap_window_reg;
    logic        sel_window;

    assign sel_window = (paddr[3] == REG_TAP_WINDOW);
    assign pready     = 1'b1;
    assign prdata     = sel_window ? tap_window_reg : '0;
    assign tap_window = tap_window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_window_reg <= TAP_WINDOW_RESET;
        end
        else if (psel && penable && pwrite && sel_window)
        begin
            tap_window_reg <= pwdata;
        end
    end

endmodule

@@ hw/rtl/kth_engine.sv @@
// ----------------------------------------------------------------------------
// kth_engine
// Command sequencer: clears the key table, reads an entry, updates it and
// writes it back, forms the result beat.
// ----------------------------------------------------------------------------
module kth_engine #(
    parameter int KEY_SLOTS = kth_pkg::KEY_SLOTS_DEFAULT,
    parameter int KW        = $clog2(KEY_SLOTS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  kth_pkg::item_t         item,
    output logic                   done,
    output kth_pkg::result_t       result,
    input  logic [63:0]            tap_window,
    output logic                   ram_we,
    output logic [KW-1:0]          ram_waddr,
    output kth_pkg::slot_t         ram_wdata,
    output logic [KW-1:0]          ram_raddr,
    input  kth_pkg::slot_t         ram_rdata
);
    import kth_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t         state_reg, state_next;
    logic [KW-1:0]  clr_reg, clr_next;
    logic [7:0]     mods_reg, mods_next;
    item_t          item_reg;
    result_t        result_reg, result_next;
    logic           done_reg, done_next;

    logic           accept;
    logic           key_ok;
    logic [KW-1:0]  key_idx;
    slot_t          cur, upd;
    logic           wr_slot;
    logic [3:0]     mods_before;
    logic [63:0]    since_rel, held_for;
    logic           tap_cont;
    logic [1:0]     action;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign key_idx   = item_reg.key_id[KW-1:0];
    assign key_ok    = ({1'b0, item_reg.key_id} < 13'(KEY_SLOTS));
    assign ram_raddr = item.key_id[KW-1:0];
    assign cur       = ram_rdata;
    assign done      = done_reg;
    assign result    = result_reg;

    assign mods_before = mod_nibble(mods_reg);
    assign since_rel   = item_reg.now_nanos - cur.release_stamp;
    assign held_for    = item_reg.now_nanos - cur.press_stamp;
    assign tap_cont    = (cur.release_stamp != '0) && (since_rel < tap_window)
                      && (cur.mods_at_tap == mods_before);

    always_comb
    begin
        upd         = cur;
        wr_slot     = 1'b0;
        mods_next   = mods_reg;
        action      = ACT_PRESS;
        result_next = '0;

        case (item_reg.cmd)
            CMD_PRESS:
            begin
                if (cur.press_stamp != '0)
                begin
                    action = ACT_REPEAT;
                end
                else
                begin
                    wr_slot = 1'b1;
                    if (tap_cont)
                        upd.taps_so_far = (cur.taps_so_far == TAPS_MAX) ?
                                          TAPS_MAX : cur.taps_so_far + 8'd1;
                    else
                        upd.taps_so_far = 8'd1;
                    upd.mods_at_tap  = mods_before;
                    upd.tap_deadline = item_reg.now_nanos + tap_window;
                    upd.press_stamp  = item_reg.now_nanos;
                    // a press at time zero leaves the modifier reading as up
                    if (item_reg.now_nanos != '0)
                        mods_next = mods_reg | mod_mask(item_reg.key_id);
                    else
                        mods_next = mods_reg & ~mod_mask(item_reg.key_id);
                end
            end
            CMD_RELEASE:
            begin
                wr_slot = 1'b1;
                action  = ACT_RELEASE;
                if (cur.press_stamp != '0)
                    upd.hold_length = held_for;
                upd.release_stamp = item_reg.now_nanos;
                upd.press_stamp   = '0;
                upd.hold_latch    = 1'b0;
                mods_next         = mods_reg & ~mod_mask(item_reg.key_id);
            end
            CMD_RESET_TAP:
            begin
                wr_slot         = 1'b1;
                upd.taps_so_far = '0;
            end
            CMD_SET_LATCH:
            begin
                wr_slot        = 1'b1;
                upd.hold_latch = item_reg.latch_value;
            end
            default:
            begin
            end
        endcase

        // rejected keys leave the key table and the modifier state alone
        if (!key_ok)
        begin
            wr_slot   = 1'b0;
            mods_next = mods_reg;
        end

        case (item_reg.cmd) inside
            CMD_CHAR:
            begin
                result_next.kind         = KIND_EVENT;
                result_next.event_word   = pack_word(item_reg.elapsed_micros, 4'b0,
                                                     item_reg.char_code, ACT_CHAR);
                result_next.event_window = item_reg.window_id;
            end
            CMD_PRESS, CMD_RELEASE:
            begin
                result_next.kind         = KIND_EVENT;
                result_next.event_word   = pack_word(item_reg.elapsed_micros,
                                                     mod_nibble(mods_next),
                                                     {4'b0, item_reg.key_id}, action);
                result_next.event_window = item_reg.window_id;
            end
            CMD_QUERY:
            begin
                result_next.kind               = KIND_QUERY;
                result_next.tap_count          = cur.taps_so_far;
                result_next.key_held           = (cur.press_stamp != '0);
                result_next.long_press_latched = cur.hold_latch;
                result_next.hold_nanos         = (cur.press_stamp != '0) ?
                                                 held_for : cur.hold_length;
                result_next.since_release_nanos = (cur.release_stamp != '0) ?
                                                  since_rel : '0;
                if (cur.taps_so_far == '0)
                    result_next.tap_phase = PHASE_NONE;
                else if (item_reg.now_nanos < cur.tap_deadline)
                    result_next.tap_phase = PHASE_PENDING;
                else if (cur.taps_so_far >= 8'd3)
                    result_next.tap_phase = PHASE_MULTI;
                else if (cur.taps_so_far == 8'd2)
                    result_next.tap_phase = PHASE_DOUBLE;
                else
                    result_next.tap_phase = PHASE_SINGLE;
            end
            default:
            begin
                result_next.kind = KIND_ACK;
            end
        endcase

        if (!key_ok && item_reg.cmd != CMD_CHAR)
        begin
            result_next      = '0;
            result_next.kind = KIND_REJECT;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = key_idx;
        ram_wdata  = upd;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == KW'(KEY_SLOTS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                ram_we     = wr_slot;
                done_next  = (item_reg.cmd <= CMD_SET_LATCH);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            mods_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            if (state_reg == S_EXEC)
                mods_reg <= mods_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        if (state_reg == S_EXEC)
            result_reg <= result_next;
    end

endmodule

@@ hw/rtl/key_tap_hold_tracker_top.sv @@
// ----------------------------------------------------------------------------
// key_tap_hold_tracker_top
// Per-key tap/hold timing table answering press, release, char, query,
// tap-reset and latch-set commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. In the accept cycle
// the key's table entry is read from the single key-table RAM, in the next
// cycle it is updated and written back, and the result beat appears on
// result with done high for exactly one cycle right after that. The receiver
// cannot stall, so done must be sampled when it shows. busy drops together
// with the result beat, so a new command can be taken in the same cycle the
// previous result is shown, but not while the previous command still runs.
// Commands 6 and 7 go through the same steps and give no beat. After reset
// the table is cleared one key slot per cycle and busy stays high until the
// last slot is cleared; configuration writes are taken meanwhile.
// The tap window register is a 64-bit APB register at byte address 0.
// ----------------------------------------------------------------------------
module key_tap_hold_tracker_top #(
    parameter int KEY_SLOTS = kth_pkg::KEY_SLOTS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // command channel
    input  logic                       start,
    output logic                       busy,
    input  kth_pkg::item_t             item,
    // result channel
    output logic                       done,
    output kth_pkg::result_t           result,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kth_pkg::APB_AW-1:0] paddr,
    input  logic [kth_pkg::APB_DW-1:0] pwdata,
    output logic [kth_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import kth_pkg::*;

    localparam int KW = $clog2(KEY_SLOTS);

    logic [63:0]   tap_window;
    logic          ram_we;
    logic [KW-1:0] ram_waddr, ram_raddr;
    slot_t         ram_wdata, ram_rdata;

    // configuration register
    kth_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .tap_window (tap_window)
    );

    // key table: one entry per key slot holding all its timing state
    kth_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (KEY_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // read-modify-write sequencer; writes land before the next read can be
    // issued, so no forwarding path is needed
    kth_engine #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .tap_window (tap_window),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

endmodule

@@ hw/rtl/kth_checker.sv @@
// ----------------------------------------------------------------------------
// kth_checker
// Port-level checks of the tracker's command/result timing and reject beats, bound to top.
// ----------------------------------------------------------------------------
`include "key_tap_hold_tracker_top_macros.svh"

module kth_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  kth_pkg::item_t   item,
    input  logic             done,
    input  kth_pkg::result_t result
);
    import kth_pkg::*;

    `KTH_ASSERT_NXT(a_busy_after_accept, start && !busy, busy, "no busy after accept")
    `KTH_ASSERT_NXT(a_done_single, done, !done, "result beat longer than one cycle")
    `KTH_ASSERT_IMP(a_done_free, done, !busy, "busy while result beat shown")
    `KTH_ASSERT_IMP(a_beat_latency, start && !busy && item.cmd <= CMD_SET_LATCH, ##2 done, "missing result beat")
    `KTH_ASSERT_IMP(a_reject_clean, done && result.kind == KIND_REJECT, result.event_word == '0, "rejected beat carries an event")

endmodule

bind key_tap_hold_tracker_top kth_checker u_checker (.*);
